[hw/rtl/assert_macros.svh]
// Assertion macros for the list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define OVLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define OVLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ovle_pkg.sv]
// Shared types and constants for the ordered value list engine.
`default_nettype none

package ovle_pkg;

  localparam int VAL_W = 32;

  typedef enum logic [2:0] {
    OP_INSERT_FRONT = 3'd0,
    OP_APPEND_BACK  = 3'd1,
    OP_SEARCH       = 3'd2,
    OP_REMOVE       = 3'd3,
    OP_CLEAR        = 3'd4,
    OP_QUERY        = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic                    found;
    logic [3:0]              position;
    logic [4:0]              count;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] back_value;
    logic                    is_empty;
    status_t                 status;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/ordered_value_list_engine_unit.sv]
// Ordered value list engine: a bounded list of signed 32-bit values behind stream ports.
//
// Input channel (in_*): one beat is one operation. in_tuser carries the op code
// (insert front, append back, search, remove first match, clear, query; codes 6
// and 7 act as query), in_tdata the 32-bit value.
// Output channel (out_*): exactly one result beat per input beat, in order:
// found flag, match position, element count, front and back values, empty flag
// and status (ok, insert dropped because full, value not found).
// Clear, query, append and full inserts go on to read the front and back entries
// (skipped when the list is empty afterwards). Insert front shifts every
// element up through the store's single write port and single read port; search
// and remove walk from the front, one store entry read or moved per cycle.
// One item is worked at a time, so the next beat is taken only once the result
// has reached the output register.
// The finished result sits in an output register, so the next beat is taken
// while that result waits on out_tready; a stalled receiver holds the sequencer
// only once a second result is ready.
// Reset (rst_n low, synchronous) empties the list and drops any pending result.
// The store itself is not cleared; only entries below the count are read.
`default_nettype none

module ordered_value_list_engine_unit #(
  parameter int CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [2:0]  in_tuser,   // [2:0] op
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [79:0] out_tdata   // [0] found, [4:1] position, [9:5] count,
                                       // [41:10] front_value, [73:42] back_value,
                                       // [74] is_empty, [76:75] status, [79:77] zero
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [ovle_pkg::VAL_W-1:0] wr_data;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [ovle_pkg::VAL_W-1:0] rd_data;

  logic              res_valid;
  logic              res_ready;
  ovle_pkg::result_t res;

  logic              out_valid_r, out_valid_nxt;
  ovle_pkg::result_t out_res_r, out_res_nxt;

  ovle_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ovle_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_value  (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // Output register takes a new result whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000,
                       out_res_r.status,
                       out_res_r.is_empty,
                       out_res_r.back_value,
                       out_res_r.front_value,
                       out_res_r.count,
                       out_res_r.position,
                       out_res_r.found};

endmodule

`default_nettype wire

[hw/rtl/ovle_store.sv]
// Element store: single write port, single registered read port.
`default_nettype none

module ovle_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic                           clk,
  input  wire logic                           wr_en,
  input  wire logic [AW-1:0]                  wr_addr,
  input  wire logic [ovle_pkg::VAL_W-1:0]     wr_data,
  input  wire logic                           rd_en,
  input  wire logic [AW-1:0]                  rd_addr,
  output      logic [ovle_pkg::VAL_W-1:0]     rd_data
);

  logic [ovle_pkg::VAL_W-1:0] mem [DEPTH];
  logic [ovle_pkg::VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[hw/rtl/ovle_seq.sv]
// Operation sequencer: walks and shifts the element store, builds one result per item.
`default_nettype none
`include "assert_macros.svh"

module ovle_seq #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // item intake
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic [2:0]                        in_op,
  input  wire logic signed [ovle_pkg::VAL_W-1:0] in_value,
  // result handoff
  output      logic                              res_valid,
  input  wire logic                              res_ready,
  output      ovle_pkg::result_t                 res,
  // store port
  output      logic                              wr_en,
  output      logic [AW-1:0]                     wr_addr,
  output      logic [ovle_pkg::VAL_W-1:0]        wr_data,
  output      logic                              rd_en,
  output      logic [AW-1:0]                     rd_addr,
  input  wire logic [ovle_pkg::VAL_W-1:0]        rd_data
);

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH,
    S_SHUP,
    S_INS0,
    S_SHDN,
    S_RDF,
    S_RDB,
    S_RDW,
    S_DONE
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [AW-1:0]              idx_r, idx_nxt;
  logic [AW-1:0]              pos_r, pos_nxt;
  logic                       found_r, found_nxt;
  ovle_pkg::status_t          status_r, status_nxt;
  logic [2:0]                 op_r, op_nxt;
  logic [ovle_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [ovle_pkg::VAL_W-1:0] front_r, front_nxt;
  logic [ovle_pkg::VAL_W-1:0] back_r, back_nxt;

  logic [AW-1:0]   last_idx;
  logic [AW-1:0]   idx_inc;
  logic [AW-1:0]   idx_dec;
  logic [AW+3:0]   pos_ext;
  logic [CW+4:0]   count_ext;

  assign last_idx = AW'(count_r - 1'b1);
  assign idx_inc  = idx_r + 1'b1;
  assign idx_dec  = idx_r - 1'b1;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    front_nxt  = front_r;
    back_nxt   = back_r;
    rd_en      = 1'b0;
    rd_addr    = idx_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_op;
          val_nxt    = in_value;
          found_nxt  = 1'b0;
          pos_nxt    = '0;
          status_nxt = ovle_pkg::ST_OK;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (ovle_pkg::op_t'(op_r))
          ovle_pkg::OP_INSERT_FRONT, ovle_pkg::OP_APPEND_BACK: begin
            if (count_r == CAP_C) begin
              status_nxt = ovle_pkg::ST_FULL;
              state_nxt  = S_RDF;
            end else if (op_r == ovle_pkg::OP_APPEND_BACK || count_r == '0) begin
              // tail slot, which is also the front slot of an empty list
              wr_en     = 1'b1;
              wr_addr   = AW'(count_r);
              wr_data   = val_r;
              count_nxt = count_r + 1'b1;
              state_nxt = S_RDF;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = last_idx;
              idx_nxt   = last_idx;
              state_nxt = S_SHUP;
            end
          end
          ovle_pkg::OP_SEARCH, ovle_pkg::OP_REMOVE: begin
            if (count_r == '0) begin
              status_nxt = ovle_pkg::ST_NOT_FOUND;
              state_nxt  = S_RDF;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              idx_nxt   = '0;
              state_nxt = S_SRCH;
            end
          end
          ovle_pkg::OP_CLEAR: begin
            count_nxt = '0;
            state_nxt = S_RDF;
          end
          default: begin
            state_nxt = S_RDF;
          end
        endcase
      end
      S_SHUP: begin
        // move entry idx up one; next read is idx-1, never the written slot
        wr_en   = 1'b1;
        wr_addr = idx_inc;
        if (idx_r == '0) begin
          state_nxt = S_INS0;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_dec;
          idx_nxt = idx_dec;
        end
      end
      S_INS0: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = val_r;
        count_nxt = count_r + 1'b1;
        state_nxt = S_RDF;
      end
      S_SRCH: begin
        if (rd_data == val_r) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r;
          if (op_r == ovle_pkg::OP_REMOVE) begin
            if (idx_r == last_idx) begin
              count_nxt = count_r - 1'b1;
              state_nxt = S_RDF;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = idx_inc;
              idx_nxt   = idx_inc;
              state_nxt = S_SHDN;
            end
          end else begin
            state_nxt = S_RDF;
          end
        end else if (idx_r == last_idx) begin
          status_nxt = ovle_pkg::ST_NOT_FOUND;
          state_nxt  = S_RDF;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_inc;
          idx_nxt = idx_inc;
        end
      end
      S_SHDN: begin
        // move entry idx down one; next read is idx+1, never the written slot
        wr_en   = 1'b1;
        wr_addr = idx_dec;
        if (idx_r == last_idx) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_RDF;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_inc;
          idx_nxt = idx_inc;
        end
      end
      S_RDF: begin
        if (count_r == '0) begin
          front_nxt = '0;
          back_nxt  = '0;
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = '0;
          state_nxt = S_RDB;
        end
      end
      S_RDB: begin
        front_nxt = rd_data;
        rd_en     = 1'b1;
        rd_addr   = last_idx;
        state_nxt = S_RDW;
      end
      S_RDW: begin
        back_nxt  = rd_data;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    front_r  <= front_nxt;
    back_r   <= back_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  // position and count are reported at their fixed widths
  assign pos_ext   = {4'b0, pos_r};
  assign count_ext = {5'b0, count_r};

  always_comb begin
    res.found       = found_r;
    res.position    = pos_ext[3:0];
    res.count       = count_ext[4:0];
    res.front_value = front_r;
    res.back_value  = back_r;
    res.is_empty    = (count_r == '0);
    res.status      = status_r;
  end

  `OVLE_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CAP_C, "count above capacity")
  `OVLE_ASSERT_IMP(a_wr_range, clk, rst_n, wr_en, CW'(wr_addr) < CAP_C, "write beyond store")
  `OVLE_ASSERT_IMP(a_no_collide, clk, rst_n, rd_en && wr_en, rd_addr != wr_addr, "read/write collide")
  `OVLE_ASSERT_NXT(a_done_hold, clk, rst_n, (state_r == S_DONE) && !res_ready, (state_r == S_DONE) && $stable(count_r) && $stable(front_r) && $stable(back_r), "result changed while held")

endmodule

`default_nettype wire

[dv/tb_ordered_value_list_engine_unit.sv]
// Self-checking testbench for the ordered value list engine stream unit.
`timescale 1ns / 100ps

module tb_ordered_value_list_engine_unit;

  localparam int LIST_DEPTH    = 16;
  localparam int RANDOM_ITEMS  = 1520;
  localparam int CALM_ITEMS    = 200;   // tail of the run with no idling on either side
  localparam int HOLD_AT_BEAT  = 500;   // input beats taken before the long result stall
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_AT_ITEM = 700;   // random item before which the sender drains the unit
  localparam int DRAIN_CYCLES  = 80;    // several times the slowest item
  localparam int WATCHDOG      = 3000;  // cycles with no beat on either side

  // Codes 6 and 7 are unused and must behave as query.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // Tracks the list contents as beats are accepted and holds the results
  // they must produce, oldest first.
  class list_scoreboard;
    logic signed [31:0] held[$];
    ovle_pkg::result_t  due[$];
    int errors, n_noted, n_checked, n_hit, n_miss, n_full, peak;
    string field_name[8] = '{"found", "position", "count", "front_value",
                             "back_value", "is_empty", "status", "pad"};

    // Apply one accepted operation to the list and queue its result.
    function void note_op(logic [2:0] op, logic signed [31:0] val);
      ovle_pkg::result_t r;
      int                hit = -1;
      r = '0;
      r.status = ovle_pkg::ST_OK;
      case (op)
        ovle_pkg::OP_INSERT_FRONT, ovle_pkg::OP_APPEND_BACK: begin
          if (held.size() >= LIST_DEPTH) begin
            r.status = ovle_pkg::ST_FULL;
            n_full++;
          end else if (op == ovle_pkg::OP_INSERT_FRONT) begin
            held.push_front(val);
          end else begin
            held.push_back(val);
          end
        end
        ovle_pkg::OP_SEARCH, ovle_pkg::OP_REMOVE: begin
          // only the first match from the front counts
          for (int i = 0; i < held.size() && hit < 0; i++)
            if (held[i] == val) hit = i;
          if (hit >= 0) begin
            r.found    = 1'b1;
            r.position = hit[3:0];
            if (op == ovle_pkg::OP_REMOVE) held.delete(hit);
            n_hit++;
          end else begin
            r.status = ovle_pkg::ST_NOT_FOUND;
            n_miss++;
          end
        end
        ovle_pkg::OP_CLEAR: held.delete();
        default: ;  // query and the spare codes leave the list alone
      endcase
      r.count    = 5'(held.size());
      r.is_empty = (held.size() == 0);
      if (held.size() != 0) begin
        r.front_value = held[0];
        r.back_value  = held[held.size() - 1];
      end
      if (held.size() > peak) peak = held.size();
      due.push_back(r);
      n_noted++;
    endfunction

    // Compare one result beat with the oldest queued result, field by field.
    function void check_result(logic [79:0] beat);
      ovle_pkg::result_t want;
      logic [31:0]       want_f[8];
      logic [31:0]       got_f[8];
      if (due.size() == 0) begin
        errors++;
        $display("%0t: result beat %h arrived with nothing outstanding", $time, beat);
        return;
      end
      want = due.pop_front();
      n_checked++;
      want_f = '{want.found, want.position, want.count, want.front_value,
                 want.back_value, want.is_empty, want.status, 3'd0};
      got_f  = '{beat[0], beat[4:1], beat[9:5], beat[41:10],
                 beat[73:42], beat[74], beat[76:75], beat[79:77]};
      for (int i = 0; i < 8; i++) begin
        if (want_f[i] !== got_f[i]) begin
          errors++;
          if (errors <= 200)
            $display("%0t: %s mismatch on result %0d, expected %h, actual %h",
                     $time, field_name[i], n_checked, want_f[i], got_f[i]);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [31:0] value
  logic [2:0]  in_tuser   = '0;   // [2:0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;         // [0] found, [4:1] position, [9:5] count,
                                  // [41:10] front_value, [73:42] back_value,
                                  // [74] is_empty, [76:75] status, [79:77] zero

  list_scoreboard sb = new();
  bit             calm;       // set for the tail of the run: no idling anywhere
  bit             hold_done;

  ordered_value_list_engine_unit #(.CAPACITY(LIST_DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one beat and hold it until the unit takes it; note it on acceptance.
  task automatic push_op(input logic [2:0] op, input logic [31:0] val);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    sb.note_op(op, val);
  endtask

  // Drop valid for a burst of cycles.
  task automatic hold_input(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Check every result beat as it is taken.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Receiver: random stall bursts, one long hold-off so the unit backs up
  // into its input, and no stalls at all in the calm tail.
  initial begin
    int rx_rate;
    int cyc;
    rx_rate = 0;
    cyc     = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) rx_rate = calm ? 0 : $urandom_range(0, 2);
      if (!hold_done && sb.n_noted >= HOLD_AT_BEAT) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (!calm && rx_rate != 0 &&
                   $urandom_range(0, rx_rate == 1 ? 9 : 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG) begin
        $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG, sb.due.size());
        $display("FAIL ordered_value_list_engine_unit");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    logic [31:0] pool[8];
    logic [2:0]  op;
    logic [31:0] val;
    int          gap_rate;
    int          roll;
    int          size;
    bit          growing;

    pool = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
             $urandom, $urandom, $urandom, $urandom};
    gap_rate = 0;
    growing  = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-list reads, extremes, duplicates, sole-element remove,
    // spare op codes, then fill to capacity and overfill from both ends.
    push_op(ovle_pkg::OP_QUERY,        32'h1234_5678);
    push_op(ovle_pkg::OP_REMOVE,       32'h0000_0005);   // miss on an empty list
    push_op(ovle_pkg::OP_INSERT_FRONT, 32'h7FFF_FFFF);
    push_op(ovle_pkg::OP_APPEND_BACK,  32'h8000_0000);
    push_op(ovle_pkg::OP_INSERT_FRONT, 32'hFFFF_FFFF);
    push_op(ovle_pkg::OP_SEARCH,       32'h8000_0000);   // hit at the back
    push_op(ovle_pkg::OP_APPEND_BACK,  32'hFFFF_FFFF);   // duplicate of the front
    push_op(ovle_pkg::OP_REMOVE,       32'hFFFF_FFFF);   // must take the front copy
    push_op(OP_SPARE_6,                32'hDEAD_BEEF);
    push_op(ovle_pkg::OP_CLEAR,        32'hA5A5_A5A5);
    push_op(ovle_pkg::OP_INSERT_FRONT, 32'h0000_002A);
    push_op(ovle_pkg::OP_REMOVE,       32'h0000_002A);   // sole element: front and back go empty
    push_op(OP_SPARE_7,                32'h5A5A_5A5A);
    for (int i = 0; i < LIST_DEPTH; i++)
      push_op(i[0] ? ovle_pkg::OP_APPEND_BACK : ovle_pkg::OP_INSERT_FRONT,
              32'h0100_0001 * (i + 1));
    push_op(ovle_pkg::OP_INSERT_FRONT, 32'h0000_0000);   // refused: full
    push_op(ovle_pkg::OP_APPEND_BACK,  32'hFFFF_FFFF);   // refused: full
    // last append sits at the back
    push_op(ovle_pkg::OP_SEARCH, 32'h0100_0001 * LIST_DEPTH);

    // Random: the list swings between empty and full, values mostly drawn
    // from a small pool or from the list itself so that matches are common.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
      if (n % 50 == 0) gap_rate = calm ? 0 : $urandom_range(0, 2);

      // drain the unit completely once, mid-run
      if (n == DRAIN_AT_ITEM) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (sb.due.size() != 0);
      end

      size = sb.held.size();
      if (size == LIST_DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
      else if (size == 0) growing = 1'b1;

      roll = $urandom_range(0, 99);
      if (roll < 2)                       op = ovle_pkg::OP_CLEAR;
      else if (roll == 2)                 op = OP_SPARE_6;
      else if (roll == 3)                 op = OP_SPARE_7;
      else if (roll < 8)                  op = ovle_pkg::OP_QUERY;
      else if (roll < 20)                 op = ovle_pkg::OP_SEARCH;
      else if (roll < (growing ? 35 : 75)) op = ovle_pkg::OP_REMOVE;
      else op = $urandom_range(0, 1) ? ovle_pkg::OP_INSERT_FRONT : ovle_pkg::OP_APPEND_BACK;

      roll = $urandom_range(0, 9);
      if ((op == ovle_pkg::OP_SEARCH || op == ovle_pkg::OP_REMOVE) && size > 0 && roll < 6)
        val = sb.held[$urandom_range(0, size - 1)];
      else if (roll < 8)
        val = pool[$urandom_range(0, 7)];
      else
        val = $urandom;
      if ($urandom_range(0, 19) == 0) pool[$urandom_range(0, 7)] = $urandom;

      push_op(op, val);
      if (!calm && gap_rate != 0 && $urandom_range(0, gap_rate == 1 ? 7 : 2) == 0)
        hold_input($urandom_range(1, 9));
    end

    // Wait for the last result, then give stray beats a chance to show up.
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d operations, checked %0d results: %0d matches, %0d misses,",
             sb.n_noted, sb.n_checked, sb.n_hit, sb.n_miss);
    $display("%0d inserts refused when full, deepest list %0d, a %0d-cycle result stall,",
             sb.n_full, sb.peak, HOLD_CYCLES);
    $display("and a full drain pause; %0d field errors.", sb.errors);
    if (sb.errors == 0) begin
      $display("PASS ordered_value_list_engine_unit");
    end else begin
      $display("FAIL ordered_value_list_engine_unit");
    end
    $finish;
  end

endmodule
